// File: design/keyed_record_table_unit_defines.svh
// assertion macros for the keyed record table unit
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KRT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define KRT_ASSERT(label, clk, rst, prop, msg)
`define KRT_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: design/krt_pkg.sv
// shared types and constants for the keyed record table unit
`default_nettype none

package krt_pkg;

  localparam int NAME_W   = 64;
  localparam int SALARY_W = 31;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LIST   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_RECORD   = 3'd0,
    ST_STORED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [NAME_W-1:0]   first_name;
    logic [NAME_W-1:0]   surname;
    logic [SALARY_W-1:0] salary;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [NAME_W-1:0]   out_first_name;
    logic [NAME_W-1:0]   out_surname;
    logic [SALARY_W-1:0] out_salary;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [NAME_W-1:0]   first_name;
    logic [NAME_W-1:0]   surname;
    logic [SALARY_W-1:0] salary;
  } rec_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

`default_nettype wire

// File: design/krt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/krt_seq.sv
// slot scan sequencer: valid marks, key compare, record hold and result push
`default_nettype none
`include "keyed_record_table_unit_defines.svh"

module krt_seq import krt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int NAME_CHARS  = 8,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire req_t            req,
  output ram_ctl_t             ram_ctl,
  output logic [IDX_W-1:0]     waddr,
  output rec_t                 wdata,
  output logic [IDX_W-1:0]     raddr,
  input  wire rec_t            rdata,
  output logic                 res_valid,
  output res_t                 res,
  input  wire logic            res_ok
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
    logic [NAME_W-1:0] r;
    logic              alive;
    logic [7:0]        b;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b = v[56-8*i +: 8];
      if (i >= NAME_CHARS || b == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[56-8*i +: 8] = b;
      end
    end
    return r;
  endfunction

  state_t               state;
  state_t               state_next;
  logic [IDX_W-1:0]     cnt;
  action_t              act;
  rec_t                 key;
  rec_t                 pend;
  logic                 pend_valid;
  logic                 found;
  logic [TABLE_DEPTH-1:0] slot_valid;

  logic cur_v;
  logic key_eq;
  logic hit;
  logic del_hit;
  logic hold;
  logic ins_free;
  logic at_last;
  logic accept;

  assign accept   = req_valid && !req_stall;
  assign cur_v    = slot_valid[cnt];
  assign key_eq   = rdata.surname == key.surname;
  assign hit      = cur_v && (act == ACT_LIST || (act == ACT_SEARCH && key_eq));
  assign del_hit  = cur_v && act == ACT_DELETE && key_eq;
  assign at_last  = cnt == LAST_IDX;
  assign hold     = state == S_CHECK && hit && pend_valid && !res_ok;
  assign ins_free = state == S_CHECK && act == ACT_INSERT && !cur_v;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!hold && (ins_free || at_last)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall     = 1'b1;
    ram_ctl.rd_en = 1'b0;
    ram_ctl.wr_en = 1'b0;
    raddr         = '0;
    waddr         = cnt;
    wdata         = key;
    res_valid     = 1'b0;
    res           = '0;
    res.status    = ST_RECORD;
    unique case (state)
      S_IDLE: begin
        req_stall     = 1'b0;
        ram_ctl.rd_en = req_valid;
      end
      S_CHECK: begin
        ram_ctl.wr_en = ins_free;
        ram_ctl.rd_en = !hold && !ins_free && !at_last;
        raddr         = cnt + IDX_W'(1);
        if (hit && pend_valid && res_ok) begin
          res_valid          = 1'b1;
          res.out_first_name = pend.first_name;
          res.out_surname    = pend.surname;
          res.out_salary     = pend.salary;
        end
      end
      S_FINISH: begin
        res_valid = res_ok;
        res.last  = 1'b1;
        unique case (act)
          ACT_INSERT: res.status = found ? ST_STORED : ST_FULL;
          ACT_LIST:   res.status = pend_valid ? ST_RECORD : ST_EMPTY;
          ACT_SEARCH: res.status = pend_valid ? ST_RECORD : ST_NOTFOUND;
          ACT_DELETE: res.status = found ? ST_DELETED : ST_EMPTY;
          default:    res.status = ST_EMPTY;
        endcase
        if (pend_valid) begin
          res.out_first_name = pend.first_name;
          res.out_surname    = pend.surname;
          res.out_salary     = pend.salary;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt        <= '0;
        found      <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == S_CHECK && !hold) begin
        if (hit) begin
          pend_valid <= 1'b1;
        end
        if (del_hit) begin
          slot_valid[cnt] <= 1'b0;
        end
        if (act == ACT_DELETE && cur_v) begin
          found <= 1'b1;
        end
        if (ins_free) begin
          slot_valid[cnt] <= 1'b1;
          found           <= 1'b1;
        end else if (!at_last) begin
          cnt <= cnt + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act            <= req.action;
      key.first_name <= norm_name(req.first_name);
      key.surname    <= norm_name(req.surname);
      key.salary     <= req.salary;
    end
    if (state == S_CHECK && !hold && hit) begin
      pend <= rdata;
    end
  end

  `KRT_ASSERT(a_write_free_slot, clk, rst, ram_ctl.wr_en |-> !slot_valid[waddr], "insert into occupied slot")
  `KRT_ASSERT_NEXT(a_write_marks, clk, rst, ram_ctl.wr_en, slot_valid[$past(waddr)], "insert not marked valid")
  `KRT_ASSERT(a_push_room, clk, rst, res_valid |-> res_ok, "result pushed into busy output")
  `KRT_ASSERT(a_status_last, clk, rst, (res_valid && res.status != ST_RECORD) |-> res.last, "status result without last")

endmodule

`default_nettype wire

// File: design/keyed_record_table_unit.sv
// keyed record table unit top level: ram, sequencer and output register
//
// A table of TABLE_DEPTH records (first name, surname key, salary) kept in a
// single-port-read ram with one valid flip-flop per slot. Each request scans
// the slots one per cycle through the ram read port, unless a found record
// waits on a stalled output: insert stops at the first free slot, list,
// delete and search walk the whole table. The unit takes one request at a
// time. Records leave in slot order and the final result of each request
// carries last.
`default_nettype none

module keyed_record_table_unit import krt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int NAME_CHARS  = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ram_ctl_t         ram_ctl;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  rec_t             wdata;
  rec_t             rdata;
  logic             push;
  res_t             push_res;
  logic             res_ok;

  krt_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (ram_ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .rd_en (ram_ctl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  krt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_CHARS  (NAME_CHARS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .ram_ctl   (ram_ctl),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_valid (push),
    .res       (push_res),
    .res_ok    (res_ok)
  );

  assign res_ok = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_res;
    end
  end

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench for the keyed record table unit: queued requests, table predictor, result checks

module tb;
  import krt_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int NAME_CHARS    = 8;
  localparam int REQUEST_COUNT = 280;
  localparam int POOL_SIZE     = 6;

  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_req_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic res_stall = 1'b0;
  logic req_stall;
  logic res_valid;
  res_t res;

  pending_req_t pending_reqs[$];
  res_t         due_results[$];
  int           accepted_count = 0;
  int           total_requests = 0;
  int           failures       = 0;
  bit           drain_next     = 1'b0;

  // shadow copy of the table
  bit                  slot_used [TABLE_DEPTH];
  logic [NAME_W-1:0]   slot_first[TABLE_DEPTH];
  logic [NAME_W-1:0]   slot_last [TABLE_DEPTH];
  logic [SALARY_W-1:0] slot_pay  [TABLE_DEPTH];

  logic [NAME_W-1:0] surname_pool[POOL_SIZE];

  int burst_left = 0;
  int gap_left   = 0;
  int stall_pct  = 0;
  int mode_left  = 0;

  keyed_record_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NAME_W-1:0] norm_name(logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    logic [7:0]        ch;
    bit                ended;
    kept  = '0;
    ended = 1'b0;
    for (int i = 0; i < 8 && i < NAME_CHARS; i++) begin
      ch = raw[63-8*i -: 8];
      if (ch == 8'h00) ended = 1'b1;
      if (!ended) kept[63-8*i -: 8] = ch;
    end
    return kept;
  endfunction

  task automatic compute_table_results(input req_t r);
    logic [NAME_W-1:0] fn;
    logic [NAME_W-1:0] sn;
    res_t              out;
    bit                placed;
    bit                any_used;
    int                hits;
    int                emitted;
    fn       = norm_name(r.first_name);
    sn       = norm_name(r.surname);
    out      = '0;
    out.last = 1'b1;
    placed   = 1'b0;
    any_used = 1'b0;
    hits     = 0;
    emitted  = 0;
    case (r.action)
      ACT_INSERT: begin
        out.status = ST_FULL;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!placed && !slot_used[i]) begin
            placed        = 1'b1;
            slot_used[i]  = 1'b1;
            slot_first[i] = fn;
            slot_last[i]  = sn;
            slot_pay[i]   = r.salary;
            out.status    = ST_STORED;
          end
        end
        due_results.push_back(out);
      end
      ACT_LIST, ACT_SEARCH: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot_used[i] && (r.action == ACT_LIST || slot_last[i] == sn)) hits++;
        if (hits == 0) begin
          out.status = (r.action == ACT_LIST) ? ST_EMPTY : ST_NOTFOUND;
          due_results.push_back(out);
        end else begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && (r.action == ACT_LIST || slot_last[i] == sn)) begin
              emitted            = emitted + 1;
              out.status         = ST_RECORD;
              out.out_first_name = slot_first[i];
              out.out_surname    = slot_last[i];
              out.out_salary     = slot_pay[i];
              out.last           = (emitted == hits);
              due_results.push_back(out);
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot_used[i]) any_used = 1'b1;
        if (any_used) begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i] && slot_last[i] == sn) slot_used[i] = 1'b0;
          out.status = ST_DELETED;
        end else begin
          out.status = ST_EMPTY;
        end
        due_results.push_back(out);
      end
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    logic fire;
    bit   take;
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      fire = req_valid && !req_stall;
      if (fire) begin
        compute_table_results(req);
        accepted_count++;
      end
      if (!(req_valid && !fire)) begin
        take = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          if (!(pending_reqs[0].drain_first && due_results.size() > 0)) take = 1'b1;
        end
        if (take) begin
          req       <= pending_reqs[0].req;
          req_valid <= 1'b1;
          void'(pending_reqs.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
            else burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d last %0b", res.status, res.last);
          failures++;
        end else begin
          want = due_results.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            failures++;
          end
          if (res.out_first_name !== want.out_first_name) begin
            $error("out_first_name: expected %h, got %h", want.out_first_name,
                   res.out_first_name);
            failures++;
          end
          if (res.out_surname !== want.out_surname) begin
            $error("out_surname: expected %h, got %h", want.out_surname, res.out_surname);
            failures++;
          end
          if (res.out_salary !== want.out_salary) begin
            $error("out_salary: expected %h, got %h", want.out_salary, res.out_salary);
            failures++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res.last);
            failures++;
          end
        end
      end
      if (mode_left <= 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [NAME_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [NAME_W-1:0] make_name(int len);
    logic [NAME_W-1:0] name;
    name = '0;
    for (int i = 0; i < len; i++) name[63-8*i -: 8] = 8'($urandom_range(1, 255));
    return name;
  endfunction

  // fill everything past the terminating zero byte with junk
  function automatic logic [NAME_W-1:0] garble_tail(logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] noisy;
    bit                ended;
    noisy = name;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (ended) noisy[63-8*i -: 8] = 8'($urandom);
      else if (name[63-8*i -: 8] == 8'h00) ended = 1'b1;
    end
    return noisy;
  endfunction

  function automatic logic [NAME_W-1:0] pick_surname();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return surname_pool[$urandom_range(0, POOL_SIZE-1)];
    if (roll < 8) return garble_tail(surname_pool[$urandom_range(0, POOL_SIZE-1)]);
    return rand_word();
  endfunction

  task automatic add_request(input action_t act, input logic [NAME_W-1:0] fn,
                             input logic [NAME_W-1:0] sn, input logic [SALARY_W-1:0] pay);
    pending_req_t p;
    p.req.action     = act;
    p.req.first_name = fn;
    p.req.surname    = sn;
    p.req.salary     = pay;
    p.drain_first    = drain_next;
    drain_next       = 1'b0;
    pending_reqs.push_back(p);
    total_requests++;
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) surname_pool[i] = make_name($urandom_range(0, 8));
  endtask

  initial begin
    int      roll;
    int      op_roll;
    bit      second_drain;
    action_t act;
    second_drain = 1'b0;

    // directed: empty table, extremes, name termination, duplicates, slot reuse
    add_request(ACT_LIST, '0, '0, '0);
    add_request(ACT_DELETE, '0, '0, '0);
    add_request(ACT_SEARCH, '1, '1, '1);
    add_request(ACT_INSERT, '1, '1, '1);
    add_request(ACT_INSERT, '0, '0, '0);
    add_request(ACT_INSERT, 64'h414E_4E00_1234_5678, 64'h4C45_4500_DEAD_BE11, 31'd12345);
    add_request(ACT_SEARCH, '0, 64'h4C45_4500_0000_0000, '0);
    add_request(ACT_SEARCH, '0, 64'h4C45_4500_FFFF_FFFF, '0);
    add_request(ACT_SEARCH, '0, 64'h4C45_4600_0000_0000, '0);
    add_request(ACT_INSERT, 64'h424F_4200_0000_0000, '1, 31'h2AAA_AAAA);
    add_request(ACT_SEARCH, '0, '1, '0);
    add_request(ACT_LIST, '0, '0, '0);
    add_request(ACT_DELETE, '0, 64'h5A5A_5A00_0000_0000, '0);
    add_request(ACT_DELETE, '0, '1, '0);
    add_request(ACT_INSERT, 64'h4D41_5800_0000_0000, 64'h4B49_4D00_0000_0000, 31'h5555_5555);
    add_request(ACT_DELETE, '0, 64'h00FF_FFFF_FFFF_FFFF, '0);
    add_request(ACT_LIST, '0, '0, '0);
    add_request(ACT_DELETE, '0, 64'h4C45_4500_0000_0000, '0);
    add_request(ACT_DELETE, '0, 64'h4B49_4D00_7777_7777, '0);
    add_request(ACT_LIST, '0, '0, '0);
    add_request(ACT_DELETE, '0, '0, '0);

    refresh_pool();
    drain_next = 1'b1;
    while (total_requests < REQUEST_COUNT) begin
      if (!second_drain && total_requests >= 150) begin
        drain_next   = 1'b1;
        second_drain = 1'b1;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) refresh_pool();
      if (roll < 2) begin
        // fill past capacity, then read back
        repeat (TABLE_DEPTH + 1)
          add_request(ACT_INSERT, rand_word(), pick_surname(), SALARY_W'($urandom));
        add_request(ACT_LIST, rand_word(), rand_word(), SALARY_W'($urandom));
        add_request(ACT_SEARCH, rand_word(), pick_surname(), SALARY_W'($urandom));
      end else if (roll == 2) begin
        // sweep the pool surnames away, then list, delete and search the table
        for (int i = 0; i < POOL_SIZE; i++)
          add_request(ACT_DELETE, rand_word(), garble_tail(surname_pool[i]),
                      SALARY_W'($urandom));
        add_request(ACT_LIST, rand_word(), rand_word(), SALARY_W'($urandom));
        add_request(ACT_DELETE, rand_word(), pick_surname(), SALARY_W'($urandom));
        add_request(ACT_SEARCH, rand_word(), pick_surname(), SALARY_W'($urandom));
      end else if (roll == 3) begin
        repeat (3)
          add_request(action_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                      SALARY_W'($urandom));
      end else begin
        repeat (6) begin
          op_roll = $urandom_range(0, 99);
          if (op_roll < 35) act = ACT_INSERT;
          else if (op_roll < 65) act = ACT_SEARCH;
          else if (op_roll < 80) act = ACT_DELETE;
          else act = ACT_LIST;
          add_request(act, rand_word(), pick_surname(), SALARY_W'($urandom));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (3 * TABLE_DEPTH) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
